// File: hdl/igsd_pkg.sv
`default_nettype none
package igsd_pkg;
  localparam int unsigned MaxDim = 8;
  localparam int unsigned IdxW = 3;
  localparam int unsigned AddrW = 6;
  localparam int unsigned DimW = 4;
  localparam int unsigned ProdW = 19;
  localparam int unsigned PaddrW = 5;

  localparam logic [1:0] OpWriteA = 2'd0;
  localparam logic [1:0] OpWriteB = 2'd1;
  localparam logic [1:0] OpCompute = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [2:0] RegRows = 3'd0;
  localparam logic [2:0] RegInner = 3'd1;
  localparam logic [2:0] RegCols = 3'd2;
  localparam logic [2:0] RegFormat = 3'd3;
  localparam logic [2:0] RegAccum = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [IdxW-1:0] row_index;
    logic [IdxW-1:0] col_index;
    logic signed [7:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic signed [ProdW-1:0] product_value;
    logic [IdxW-1:0] out_row;
    logic [IdxW-1:0] out_col;
    logic last;
    logic error;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic rd;
    logic [IdxW-1:0] r;
    logic [IdxW-1:0] c;
    logic [IdxW-1:0] k;
    logic [1:0] si;
    logic [1:0] tj;
    logic fmt;
  } dp_cmd_t;

  function automatic logic signed [4:0] slice_of(input logic signed [7:0] v,
                                                 input logic [1:0] which,
                                                 input logic fmt);
    logic signed [8:0] x;
    logic signed [4:0] d0;
    logic signed [4:0] d1;
    logic signed [8:0] x1;
    logic signed [8:0] x2;
    x = 9'(v);
    if (!fmt) begin
      d0 = 5'(signed'({x[3], x[2:0]}));
      x1 = (x - 9'(d0)) >>> 4;
      slice_of = (which == 2'd0) ? d0 : 5'(x1);
    end else begin
      d0 = 5'(signed'({x[2], x[1:0]}));
      x1 = (x - 9'(d0)) >>> 3;
      d1 = 5'(signed'({x1[2], x1[1:0]}));
      x2 = (x1 - 9'(d1)) >>> 3;
      case (which)
        2'd0: slice_of = d0;
        2'd1: slice_of = d1;
        default: slice_of = 5'(x2);
      endcase
    end
  endfunction
endpackage
`default_nettype wire

// File: hdl/igsd_stream_if.sv
`default_nettype none
interface igsd_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/igsd_datapath.sv
`default_nettype none
module igsd_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_a_i,
  input  wire logic wr_b_i,
  input  wire logic [igsd_pkg::AddrW-1:0] wr_addr_i,
  input  wire logic signed [7:0] wr_data_i,
  input  wire igsd_pkg::dp_cmd_t cmd_i,
  output logic signed [igsd_pkg::ProdW-1:0] acc_o
);
  logic signed [7:0] a_mem [64];
  logic signed [7:0] b_mem [64];
  logic signed [7:0] a_q, b_q;
  logic [1:0] si_q, tj_q;
  logic fmt_q, acc_q, acc_en_q;
  logic signed [9:0] prod_q;
  logic [3:0] sh_q;
  logic signed [igsd_pkg::ProdW-1:0] acc_q2;
  logic signed [4:0] sa, sb;
  logic [3:0] sh;

  always_ff @(posedge clk_i) begin
    if (wr_a_i) a_mem[wr_addr_i] <= wr_data_i;
    if (wr_b_i) b_mem[wr_addr_i] <= wr_data_i;
    a_q <= a_mem[{cmd_i.r, cmd_i.k}];
    b_q <= b_mem[{cmd_i.k, cmd_i.c}];
  end

  assign sa = igsd_pkg::slice_of(a_q, si_q, fmt_q);
  assign sb = igsd_pkg::slice_of(b_q, tj_q, fmt_q);
  assign sh = fmt_q ? 4'(3 * (si_q + tj_q)) :
                      {si_q[0] & tj_q[0], si_q[0] ^ tj_q[0], 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      si_q <= '0; tj_q <= '0; fmt_q <= 1'b0; acc_q <= 1'b0; acc_en_q <= 1'b0;
      prod_q <= '0; sh_q <= '0; acc_q2 <= '0;
    end else begin
      si_q <= cmd_i.si;
      tj_q <= cmd_i.tj;
      fmt_q <= cmd_i.fmt;
      acc_q <= cmd_i.rd;
      acc_en_q <= acc_q;
      prod_q <= 10'(sa) * 10'(sb);
      sh_q <= sh;
      if (cmd_i.clear) acc_q2 <= '0;
      else if (acc_en_q) acc_q2 <= acc_q2 + (19'(prod_q) <<< sh_q);
    end
  end
  assign acc_o = acc_q2;
endmodule
`default_nettype wire

// File: hdl/igsd_ctrl.sv
`default_nettype none
module igsd_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [igsd_pkg::DimW-1:0] rows_i,
  input  wire logic [igsd_pkg::DimW-1:0] inner_i,
  input  wire logic [igsd_pkg::DimW-1:0] cols_i,
  input  wire logic fmt_i,
  input  wire logic [5:0] accb_i,
  input  wire logic signed [igsd_pkg::ProdW-1:0] acc_i,
  input  wire logic out_ready_i,
  output logic busy_o,
  output logic out_valid_o,
  output igsd_pkg::out_word_t out_o,
  output igsd_pkg::dp_cmd_t cmd_o
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_RUN = 5'b00010, S_DRAIN = 5'b00100,
    S_OUT = 5'b01000, S_ERR = 5'b10000
  } state_e;
  state_e state_q, state_d;
  logic [2:0] r_q, c_q, k_q;
  logic [1:0] si_q, tj_q;
  logic [1:0] dr_q;
  logic [1:0] top;
  logic bad, k_end, tj_end, si_end;

  assign top = fmt_i ? 2'd2 : 2'd1;
  assign bad = rows_i == 0 || inner_i == 0 || cols_i == 0 || rows_i > 8 ||
               inner_i > 8 || cols_i > 8 || accb_i < (fmt_i ? 6'd4 : 6'd6);
  assign k_end = 4'(k_q) + 4'd1 == inner_i;
  assign tj_end = tj_q == top;
  assign si_end = si_q == top;

  always_comb begin
    cmd_o = '0;
    cmd_o.r = r_q; cmd_o.c = c_q; cmd_o.k = k_q;
    cmd_o.si = si_q; cmd_o.tj = tj_q; cmd_o.fmt = fmt_i;
    cmd_o.rd = state_q == S_RUN;
    cmd_o.clear = state_q == S_IDLE || (state_q == S_OUT && out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = bad ? S_ERR : S_RUN;
      S_RUN: if (k_end && tj_end && si_end) state_d = S_DRAIN;
      S_DRAIN: if (dr_q == 2'd1) state_d = S_OUT;
      S_OUT: if (out_ready_i) begin
        if (4'(r_q) + 1 == rows_i && 4'(c_q) + 1 == cols_i) state_d = S_IDLE;
        else state_d = S_RUN;
      end
      S_ERR: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q <= '0; c_q <= '0; k_q <= '0; si_q <= '0; tj_q <= '0; dr_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          r_q <= '0; c_q <= '0; k_q <= '0; si_q <= '0; tj_q <= '0; dr_q <= '0;
        end
        S_RUN: begin
          dr_q <= 2'd2;
          if (k_end) begin
            k_q <= '0;
            if (tj_end) begin
              tj_q <= '0;
              si_q <= si_end ? 2'd0 : si_q + 2'd1;
            end else tj_q <= tj_q + 2'd1;
          end else k_q <= k_q + 3'd1;
        end
        S_DRAIN: dr_q <= dr_q - 2'd1;
        S_OUT: if (out_ready_i) begin
          dr_q <= '0;
          if (4'(c_q) + 1 == cols_i) begin
            c_q <= '0; r_q <= r_q + 3'd1;
          end else c_q <= c_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT || state_q == S_ERR;
  always_comb begin
    out_o = '0;
    if (state_q == S_ERR) begin
      out_o.last = 1'b1; out_o.error = 1'b1;
    end else begin
      out_o.product_value = acc_i;
      out_o.out_row = r_q; out_o.out_col = c_q;
      out_o.last = 4'(r_q) + 1 == rows_i && 4'(c_q) + 1 == cols_i;
    end
  end
endmodule
`default_nettype wire

// File: hdl/int8_gemm_slice_decomposed_top.sv
// Operation: loads fill the A/B stores; a compute accumulates each entry
// over slice pairs (2 or 3 slices) and inner_count, plus output stall.
// Throughput: one load word per cycle while idle; one compute at a time,
// set by the single shared slice multiply-accumulate unit.
// Reset: asynchronous active low; registers return to 8/8/8/0/24, stores
// hold undefined data until written.
`default_nettype none
module int8_gemm_slice_decomposed_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  igsd_stream_if.sink in_if,
  igsd_stream_if.source out_if,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [igsd_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [3:0] rows_q, inner_q, cols_q;
  logic fmt_q;
  logic [5:0] accb_q;
  logic busy, acc_in, wr_a, wr_b;
  logic [2:0] reg_sel;
  igsd_pkg::in_word_t w;
  igsd_pkg::dp_cmd_t cmd;
  igsd_pkg::out_word_t ow;
  logic signed [igsd_pkg::ProdW-1:0] acc;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 4'd8; inner_q <= 4'd8; cols_q <= 4'd8; fmt_q <= 1'b0; accb_q <= 6'd24;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        igsd_pkg::RegRows: rows_q <= pwdata[3:0];
        igsd_pkg::RegInner: inner_q <= pwdata[3:0];
        igsd_pkg::RegCols: cols_q <= pwdata[3:0];
        igsd_pkg::RegFormat: fmt_q <= pwdata[0];
        igsd_pkg::RegAccum: accb_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_sel)
      igsd_pkg::RegRows: prdata = 32'(rows_q);
      igsd_pkg::RegInner: prdata = 32'(inner_q);
      igsd_pkg::RegCols: prdata = 32'(cols_q);
      igsd_pkg::RegFormat: prdata = 32'(fmt_q);
      igsd_pkg::RegAccum: prdata = 32'(accb_q);
      default: prdata = '0;
    endcase
  end

  assign w = in_if.data;
  assign in_if.ready = !busy;
  assign acc_in = in_if.valid && !busy;
  assign wr_a = acc_in && w.opcode == igsd_pkg::OpWriteA;
  assign wr_b = acc_in && w.opcode == igsd_pkg::OpWriteB;

  igsd_datapath u_dp (
    .clk_i, .rst_ni, .wr_a_i(wr_a), .wr_b_i(wr_b),
    .wr_addr_i({w.row_index, w.col_index}), .wr_data_i(w.entry_value),
    .cmd_i(cmd), .acc_o(acc)
  );

  igsd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(acc_in && w.opcode == igsd_pkg::OpCompute),
    .rows_i(rows_q), .inner_i(inner_q), .cols_i(cols_q), .fmt_i(fmt_q),
    .accb_i(accb_q), .acc_i(acc), .out_ready_i(out_if.ready), .busy_o(busy),
    .out_valid_o(out_if.valid), .out_o(ow), .cmd_o(cmd)
  );
  assign out_if.data = ow;
endmodule
`default_nettype wire
